/* design/bitmap_first_free_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap allocator
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bffa_pkg.sv */
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-free allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int NUM_W     = 11;
  localparam int BASE_W    = NUM_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [NUM_W-1:0] CAP_RESET = 11'd1024;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic MAP_INODE = 1'b0;
  localparam logic MAP_BLOCK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INODE_CAP = 2'd0,
    REG_BLOCK_CAP = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FREE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE
  } state_e;

endpackage

/* design/bitmap_first_free_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over an inode bitmap and a block bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   An item (action, map_sel, item_number) is taken when start_i is high and
//   busy_o is low. One result (status, granted_number, free_count) follows,
//   shown for one cycle with done_o; the receiver cannot stall it, so it
//   must take it in that cycle. busy_o drops in the same cycle as done_o.
//   Allocate: the map words are read one per cycle from the bitmap RAM and
//   searched by a priority encoder; the result shows once a free bit is
//   found or the last word within the capacity has been searched.
//   Free: word index and bit come from the number by a reciprocal multiply,
//   then the word is read, checked and written back.
//   Out-of-range frees and allocates at zero capacity answer straight from idle.
//   The word read/modify/write loop sets the rate: one item at a time.
//   Reset: capacities go to 1024, counts to zero, then both bitmaps are
//   cleared, one word per cycle, over all ceil(MAP_BITS/WORD_BITS) words,
//   with busy_o high. Capacity writes are taken at any time, cfg_ready_o is
//   always high; write them only while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
  parameter int MAP_BITS  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           action_i,
  input  logic                           map_sel_i,
  input  logic [bffa_pkg::NUM_W-1:0]     item_number_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [bffa_pkg::NUM_W-1:0]     granted_number_o,
  output logic [bffa_pkg::NUM_W-1:0]     free_count_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bffa_pkg::NUM_W-1:0]     cfg_data_i
);

  localparam int NumW     = bffa_pkg::NUM_W;
  localparam int BaseW    = bffa_pkg::BASE_W;
  localparam int MapWords = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int BitW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int MapCap   = (MAP_BITS > 2047) ? 2047 : MAP_BITS;
  localparam int RecipS   = NumW + BitW;
  localparam int ProdW    = NumW + RecipS;

  localparam logic [NumW-1:0]   MapCapW   = NumW'(MapCap);
  localparam logic [NumW-1:0]   WordNum   = NumW'(WORD_BITS);
  localparam logic [BaseW-1:0]  WordBase  = BaseW'(WORD_BITS);
  localparam logic [AddrW-1:0]  LastWord  = AddrW'(MapWords - 1);
  localparam logic [RecipS-1:0] RecipM    =
    RecipS'(((1 << RecipS) + WORD_BITS - 1) / WORD_BITS);

  bffa_pkg::state_e  state_q, state_d;
  bffa_pkg::status_e status_q, status_d;

  logic                 sel_q, sel_d;
  logic [AddrW-1:0]     w_q, w_d;
  logic [BaseW-1:0]     base_q, base_d;
  logic [BitW-1:0]      off_q, off_d;
  logic [AddrW-1:0]     clr_q, clr_d;
  logic [NumW-1:0]      inode_cap_q, block_cap_q;
  logic [NumW-1:0]      inode_used_q, block_used_q;
  logic                 done_q, done_d;
  logic [NumW-1:0]      granted_q, granted_d;
  logic [NumW-1:0]      free_q, free_d;

  logic                 accept;
  logic                 sel_cur;
  logic [NumW-1:0]      cap_cur, usable, used_cur, used_new;
  logic                 used_wr;
  logic                 num_bad;
  logic [NumW-1:0]      num_m1, num_quot;
  logic [ProdW-1:0]     quot_prod;
  logic [AddrW-1:0]     num_word;
  logic [BitW-1:0]      num_bit;
  logic [WORD_BITS-1:0] rd_inode, rd_block, rdata, avail, wdata;
  logic                 found, last;
  logic [BitW-1:0]      idx;
  logic [AddrW-1:0]     raddr, waddr;
  logic                 we_inode, we_block;

  assign accept  = start_i && !busy_o;
  assign sel_cur = (state_q == bffa_pkg::ST_IDLE) ? map_sel_i : sel_q;
  assign cap_cur = (sel_cur == bffa_pkg::MAP_BLOCK) ? block_cap_q : inode_cap_q;
  assign usable  = (cap_cur > MapCapW) ? MapCapW : cap_cur;
  assign used_cur = (sel_cur == bffa_pkg::MAP_BLOCK) ? block_used_q : inode_used_q;
  assign num_bad = (item_number_i == '0) || (item_number_i > usable);
  assign rdata   = (sel_q == bffa_pkg::MAP_BLOCK) ? rd_block : rd_inode;
  assign last    = (base_q + WordBase) >= {1'b0, usable};

  // word and bit of number - 1, exact for every 11-bit number
  assign num_m1    = item_number_i - NumW'(1);
  assign quot_prod = ProdW'(num_m1) * ProdW'(RecipM);
  assign num_quot  = quot_prod[ProdW-1:RecipS];
  assign num_word  = AddrW'(num_quot);
  assign num_bit   = BitW'(num_m1 - NumW'(num_quot * WordNum));

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = !rdata[b] && ((base_q + BaseW'(b)) < {1'b0, usable});
    end
  end

  bffa_prio #(
    .WIDTH (WORD_BITS),
    .IDX_W (BitW)
  ) u_prio (
    .req_i   (avail),
    .found_o (found),
    .idx_o   (idx)
  );

  bffa_ram #(
    .DEPTH  (MapWords),
    .WIDTH  (WORD_BITS),
    .ADDR_W (AddrW)
  ) u_inode_ram (
    .clk_i   (clk_i),
    .we_i    (we_inode),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_inode)
  );

  bffa_ram #(
    .DEPTH  (MapWords),
    .WIDTH  (WORD_BITS),
    .ADDR_W (AddrW)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (we_block),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_block)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bffa_pkg::ST_CLEAR: begin
        if (clr_q == LastWord) begin
          state_d = bffa_pkg::ST_IDLE;
        end
      end
      bffa_pkg::ST_IDLE: begin
        if (accept) begin
          if (action_i == bffa_pkg::ACT_ALLOC) begin
            if (usable != '0) begin
              state_d = bffa_pkg::ST_ALLOC;
            end
          end else if (!num_bad) begin
            state_d = bffa_pkg::ST_FREE;
          end
        end
      end
      bffa_pkg::ST_ALLOC: begin
        if (found || last) begin
          state_d = bffa_pkg::ST_IDLE;
        end
      end
      bffa_pkg::ST_FREE: begin
        state_d = bffa_pkg::ST_IDLE;
      end
      default: begin
        state_d = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and RAM control
  always_comb begin
    sel_d     = sel_q;
    w_d       = w_q;
    base_d    = base_q;
    off_d     = off_q;
    clr_d     = clr_q;
    raddr     = '0;
    waddr     = w_q;
    wdata     = rdata;
    we_inode  = 1'b0;
    we_block  = 1'b0;
    used_new  = used_cur;
    used_wr   = 1'b0;
    done_d    = 1'b0;
    status_d  = status_q;
    granted_d = '0;
    case (state_q)
      bffa_pkg::ST_CLEAR: begin
        waddr    = clr_q;
        wdata    = '0;
        we_inode = 1'b1;
        we_block = 1'b1;
        clr_d    = clr_q + AddrW'(1);
      end
      bffa_pkg::ST_IDLE: begin
        if (accept) begin
          sel_d  = map_sel_i;
          w_d    = '0;
          base_d = '0;
          if (action_i == bffa_pkg::ACT_ALLOC) begin
            if (usable == '0) begin
              done_d   = 1'b1;
              status_d = bffa_pkg::STAT_FULL;
            end
          end else if (num_bad) begin
            done_d   = 1'b1;
            status_d = bffa_pkg::STAT_RANGE;
          end else begin
            raddr = num_word;
            w_d   = num_word;
            off_d = num_bit;
          end
        end
      end
      bffa_pkg::ST_ALLOC: begin
        if (found) begin
          wdata     = rdata | (WORD_BITS'(1) << idx);
          we_inode  = (sel_q == bffa_pkg::MAP_INODE);
          we_block  = (sel_q == bffa_pkg::MAP_BLOCK);
          used_new  = used_cur + NumW'(1);
          used_wr   = 1'b1;
          done_d    = 1'b1;
          status_d  = bffa_pkg::STAT_OK;
          granted_d = NumW'(base_q + BaseW'(idx) + BaseW'(1));
        end else if (last) begin
          done_d   = 1'b1;
          status_d = bffa_pkg::STAT_FULL;
        end else begin
          raddr  = w_q + AddrW'(1);
          w_d    = w_q + AddrW'(1);
          base_d = base_q + WordBase;
        end
      end
      bffa_pkg::ST_FREE: begin
        done_d = 1'b1;
        if (!rdata[off_q]) begin
          status_d = bffa_pkg::STAT_FREE;
        end else begin
          wdata    = rdata & ~(WORD_BITS'(1) << off_q);
          we_inode = (sel_q == bffa_pkg::MAP_INODE);
          we_block = (sel_q == bffa_pkg::MAP_BLOCK);
          used_new = (used_cur != '0) ? used_cur - NumW'(1) : used_cur;
          used_wr  = 1'b1;
          status_d = bffa_pkg::STAT_OK;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
    free_d = (used_new >= usable) ? '0 : usable - used_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bffa_pkg::ST_CLEAR;
      clr_q        <= '0;
      done_q       <= 1'b0;
      inode_cap_q  <= bffa_pkg::CAP_RESET;
      block_cap_q  <= bffa_pkg::CAP_RESET;
      inode_used_q <= '0;
      block_used_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bffa_pkg::REG_INODE_CAP: inode_cap_q <= cfg_data_i;
          bffa_pkg::REG_BLOCK_CAP: block_cap_q <= cfg_data_i;
          default: begin
            inode_cap_q <= inode_cap_q;
          end
        endcase
      end
      if (used_wr) begin
        if (sel_q == bffa_pkg::MAP_BLOCK) begin
          block_used_q <= used_new;
        end else begin
          inode_used_q <= used_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q     <= sel_d;
    w_q       <= w_d;
    base_q    <= base_d;
    off_q     <= off_d;
    status_q  <= status_d;
    if (done_d) begin
      granted_q <= granted_d;
      free_q    <= free_d;
    end
  end

  assign busy_o           = (state_q != bffa_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_number_o = granted_q;
  assign free_count_o     = free_q;
  assign cfg_ready_o      = 1'b1;

endmodule

/* design/bffa_ram.sv */
// ----------------------------------------------------------------------------
// bffa_ram
// Single-port-write, single-port-read bitmap word store, registered read.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bffa_prio.sv */
// ----------------------------------------------------------------------------
// bffa_prio
// Lowest-set-bit priority encoder over one bitmap word.
// ----------------------------------------------------------------------------
module bffa_prio #(
  parameter int WIDTH = 32,
  parameter int IDX_W = 5
) (
  input  logic [WIDTH-1:0] req_i,
  output logic             found_o,
  output logic [IDX_W-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        idx_o = IDX_W'(i);
      end
    end
  end

  assign found_o = |req_i;

endmodule

/* design/bffa_checker.sv */
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_assert.svh"

module bffa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic [bffa_pkg::NUM_W-1:0] granted_number_o
);

  `BFFA_ASSERT_SAME(a_done_idle, done_o, !busy_o, "result shown while still busy")
  `BFFA_ASSERT_NEXT(a_item_tracked, start_i && !busy_o, done_o || busy_o, "item dropped")
  `BFFA_ASSERT_SAME(a_grant_ok, done_o && (granted_number_o != '0), status_o == bffa_pkg::STAT_OK, "grant without ok status")
  `BFFA_ASSERT_SAME(a_fail_no_grant, done_o && (status_o != bffa_pkg::STAT_OK), granted_number_o == '0, "grant on failed item")

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the bitmap first-free allocator
// Drives alloc and free items into the inode and block maps at varied
// capacities and checks every result against a first-fit predictor with its
// own copy of both bitmaps, used counts and capacities.
// ----------------------------------------------------------------------------
module testbench;
  import bffa_pkg::*;

  localparam int MAP_SIZE = 1024;

  typedef struct packed {
    logic             action;
    logic             map_sel;
    logic [NUM_W-1:0] number;
  } request_t;

  typedef struct packed {
    status_e          status;
    logic [NUM_W-1:0] granted;
    logic [NUM_W-1:0] free_cnt;
  } answer_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 start_i       = 1'b0;
  logic                 action_i      = ACT_ALLOC;
  logic                 map_sel_i     = MAP_INODE;
  logic [NUM_W-1:0]     item_number_i = '0;
  logic                 cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = REG_INODE_CAP;
  logic [NUM_W-1:0]     cfg_data_i    = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [NUM_W-1:0]     granted_number_o;
  logic [NUM_W-1:0]     free_count_o;
  logic                 cfg_ready_o;

  // predictor state
  logic [MAP_SIZE-1:0] taken_bits [2];
  logic [NUM_W-1:0]    used_cnt [2];
  logic [NUM_W-1:0]    capacity [2];

  request_t queued_requests [$];
  answer_t  awaited_results [$];
  request_t next_req;
  request_t seen_req;
  answer_t  want;
  bit       item_taken = 1'b0;
  bit       in_flight  = 1'b0;
  bit       gaps_on    = 1'b1;
  int       gap_left   = 0;
  int       errors     = 0;
  int       accepted   = 0;
  int       checked    = 0;
  int       status_hits [4];
  int       alloc_pct;

  bitmap_first_free_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .map_sel_i        (map_sel_i),
    .item_number_i    (item_number_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_number_o (granted_number_o),
    .free_count_o     (free_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic answer_t first_fit_step(request_t rq);
    answer_t a;
    int      sel;
    int      usable;
    sel      = rq.map_sel;
    usable   = (capacity[sel] > MAP_SIZE) ? MAP_SIZE : capacity[sel];
    a.status = STAT_OK;
    a.granted = '0;
    if (rq.action == ACT_ALLOC) begin
      a.status = STAT_FULL;
      for (int i = 0; i < usable; i++) begin
        if (a.status == STAT_FULL && !taken_bits[sel][i]) begin
          taken_bits[sel][i] = 1'b1;
          used_cnt[sel]      = used_cnt[sel] + 1'b1;
          a.granted          = NUM_W'(i + 1);
          a.status           = STAT_OK;
        end
      end
    end else if (rq.number == 0 || rq.number > usable) begin
      a.status = STAT_RANGE;
    end else if (!taken_bits[sel][rq.number - 1]) begin
      a.status = STAT_FREE;
    end else begin
      taken_bits[sel][rq.number - 1] = 1'b0;
      if (used_cnt[sel] != 0) used_cnt[sel] = used_cnt[sel] - 1'b1;
    end
    a.free_cnt = (used_cnt[sel] >= usable) ? '0 : NUM_W'(usable - used_cnt[sel]);
    return a;
  endfunction

  // frees mostly hit 1..span of the live range, the rest probe the edges or take any 11-bit number
  function automatic request_t random_request(int alloc_share, int block_share, int span);
    request_t rq;
    int       usable;
    int       r;
    rq.action  = ($urandom_range(99) < alloc_share) ? ACT_ALLOC : ACT_FREE;
    rq.map_sel = ($urandom_range(99) < block_share) ? MAP_BLOCK : MAP_INODE;
    usable     = (capacity[rq.map_sel] > MAP_SIZE) ? MAP_SIZE : capacity[rq.map_sel];
    if (span > usable) span = usable;
    r = $urandom_range(99);
    if (rq.action == ACT_ALLOC) rq.number = NUM_W'($urandom_range(2047));
    else if (r < 75 && span > 0) rq.number = NUM_W'($urandom_range(span, 1));
    else if (r < 85) rq.number = NUM_W'(usable + $urandom_range(2));
    else if (r < 92) rq.number = '0;
    else rq.number = NUM_W'($urandom_range(2047));
    return rq;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [NUM_W-1:0] pick_cap();
    int edges [6] = '{0, 1, 32, 1023, 1024, 2047};
    if ($urandom_range(99) < 30) return NUM_W'(edges[$urandom_range(5)]);
    return NUM_W'($urandom_range(80, 1));
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (queued_requests.size() != 0) begin
        next_req      = queued_requests.pop_front();
        in_flight     = 1'b1;
        action_i      <= next_req.action;
        map_sel_i     <= next_req.map_sel;
        item_number_i <= next_req.number;
        start_i       <= 1'b1;
        gap_left      = pick_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb: result with none expected: status %0d granted %0d free %0d",
                     status_o, granted_number_o, free_count_o);
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (status_o !== want.status || granted_number_o !== want.granted ||
              free_count_o !== want.free_cnt) begin
            errors++;
            if (errors <= 10)
              $display("tb: mismatch on result %0d: status %0d/%0d granted %0d/%0d free %0d/%0d",
                       checked, want.status, status_o, want.granted, granted_number_o,
                       want.free_cnt, free_count_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        seen_req = '{action: action_i, map_sel: map_sel_i, number: item_number_i};
        want     = first_fit_step(seen_req);
        awaited_results.push_back(want);
        status_hits[want.status]++;
        accepted++;
        item_taken = 1'b1;
        in_flight  = 1'b0;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || in_flight || awaited_results.size() != 0 || busy_o);
  endtask

  // entered at a falling edge; leaves valid low at a falling edge
  task automatic set_caps(input logic [NUM_W-1:0] inode_cap, input logic [NUM_W-1:0] block_cap);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_INODE_CAP;
    cfg_data_i  <= inode_cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    capacity[MAP_INODE] = inode_cap;
    @(negedge clk_i);
    cfg_index_i <= REG_BLOCK_CAP;
    cfg_data_i  <= block_cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    capacity[MAP_BLOCK] = block_cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_req(input logic act, input logic sel, input int num);
    queued_requests.push_back('{action: act, map_sel: sel, number: NUM_W'(num)});
  endtask

  initial begin
    taken_bits[0] = '0;
    taken_bits[1] = '0;
    used_cnt[0]   = '0;
    used_cnt[1]   = '0;
    capacity[0]   = CAP_RESET;
    capacity[1]   = CAP_RESET;
    for (int s = 0; s < 4; s++) status_hits[s] = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacities: first fit, reuse of a freed hole, range edges
    push_req(ACT_ALLOC, MAP_INODE, 0);
    push_req(ACT_ALLOC, MAP_INODE, 0);
    push_req(ACT_ALLOC, MAP_INODE, 0);
    push_req(ACT_ALLOC, MAP_BLOCK, 0);
    push_req(ACT_ALLOC, MAP_BLOCK, 2047);
    push_req(ACT_FREE, MAP_INODE, 2);
    push_req(ACT_FREE, MAP_INODE, 2);
    push_req(ACT_ALLOC, MAP_INODE, 0);
    push_req(ACT_FREE, MAP_INODE, 0);
    push_req(ACT_FREE, MAP_INODE, 1025);
    push_req(ACT_FREE, MAP_INODE, 2047);
    push_req(ACT_FREE, MAP_INODE, 1024);
    push_req(ACT_FREE, MAP_BLOCK, 1);
    push_req(ACT_FREE, MAP_BLOCK, 1024);
    wait_idle();

    // zero capacity and capacity above map size
    set_caps(11'd0, 11'd2047);
    push_req(ACT_ALLOC, MAP_INODE, 0);
    push_req(ACT_FREE, MAP_INODE, 1);
    push_req(ACT_ALLOC, MAP_BLOCK, 0);
    push_req(ACT_FREE, MAP_BLOCK, 1024);
    push_req(ACT_FREE, MAP_BLOCK, 1025);
    wait_idle();

    // capacity lowered below the used count
    set_caps(11'd2, 11'd1);
    push_req(ACT_ALLOC, MAP_INODE, 0);
    push_req(ACT_FREE, MAP_INODE, 3);
    push_req(ACT_FREE, MAP_INODE, 2);
    push_req(ACT_ALLOC, MAP_BLOCK, 0);
    push_req(ACT_FREE, MAP_BLOCK, 1);
    push_req(ACT_ALLOC, MAP_BLOCK, 1);
    wait_idle();

    // long alloc-heavy run so the scan reaches deep words
    set_caps(CAP_RESET, CAP_RESET);
    repeat (500) queued_requests.push_back(random_request(85, 90, 600));

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      set_caps(pick_cap(), pick_cap());
      gaps_on   = (p % 3 != 0);
      alloc_pct = 35 + 15 * $urandom_range(2);
      repeat (95) queued_requests.push_back(random_request(alloc_pct, $urandom_range(100), 1024));
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    errors += awaited_results.size();
    $display("tb: %0d items taken, %0d results checked, %0d mismatches", accepted, checked,
             errors);
    $display("tb: status mix ok %0d, full %0d, out of range %0d, already free %0d",
             status_hits[STAT_OK], status_hits[STAT_FULL], status_hits[STAT_RANGE],
             status_hits[STAT_FREE]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* bitmap_first_free_allocator.f */
+incdir+design
design/bffa_pkg.sv
design/bffa_ram.sv
design/bffa_prio.sv
design/bitmap_first_free_allocator.sv
design/bffa_checker.sv
dv/testbench.sv
